// ===== src/qts_pkg.sv =====
// Shared constants and codes for the quadrant texture scaler.
package qts_pkg;

    localparam int TEXEL_COUNT_DEF = 65536;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] COLS_RESET = 13'd256;
    localparam logic [CFG_W-1:0] ROWS_RESET = 13'd256;

    localparam logic REG_IMAGE_COLS = 1'b0;
    localparam logic REG_IMAGE_ROWS = 1'b1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // divider geometry: 25-bit dividend, 13-bit divisor, one quotient bit per stage
    localparam int DIV_N = 25;
    localparam int DIV_D = 13;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RECT  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

endpackage

// ===== src/qts_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module qts_div_pipe #(
    parameter int N = qts_pkg::DIV_N,
    parameter int D = qts_pkg::DIV_D
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient
);

    logic [N-1:0] dq_reg  [N];
    logic [D-1:0] rem_reg [N-1];
    logic [D-1:0] dvs_reg [N-1];

    genvar g;
    for (g = 0; g < N; g++) begin : g_step
        logic [D-1:0] rem_in;
        logic [N-1:0] dq_in;
        logic [D-1:0] dvs_in;
        logic [D:0]   trial;
        logic         qbit;
        logic [D-1:0] rem_next;
        logic [N-1:0] dq_next;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = dividend;
            assign dvs_in = divisor;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign dq_in  = dq_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
        end

        assign trial    = {rem_in, dq_in[N-1]};
        assign qbit     = (trial >= {1'b0, dvs_in});
        assign rem_next = qbit ? D'(trial - {1'b0, dvs_in}) : trial[D-1:0];
        assign dq_next  = {dq_in[N-2:0], qbit};

        always_ff @(posedge aclk) begin
            if (en) begin
                dq_reg[g] <= dq_next;
            end
        end

        if (g < N - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g] <= rem_next;
                    dvs_reg[g] <= dvs_in;
                end
            end
        end
    end

    assign quotient = dq_reg[N-1];

endmodule

// ===== src/quadrant_texture_scaler_unit.sv =====
// Quadrant texture scaler: texel store with nearest-neighbor quadrant sampling.
//
// Takes one beat per clock on the input stream and, while m_tready is high,
// delivers one result per sample beat at the same rate; load beats write the
// texel store and produce no result. From s_tdata capture to m_tvalid a beat
// passes 3 entry stages, a 25-stage bit-serial divider pipeline (one
// quotient bit per stage, four dividers side by side), 3 index stages and the
// registered store read. The whole pipeline holds when a result waits on
// m_tready, so s_tready follows that stall. The store is a single-port RAM of
// TEXEL_COUNT 24-bit entries accessed at one stage, in beat order, so a sample
// sees every load accepted before it; it needs no clearing pass, and entries
// must be loaded before they are sampled. image_cols and image_rows are to be
// written over APB while the stream is idle; the block does not enforce this.
module quadrant_texture_scaler_unit #(
    parameter int TEXEL_COUNT = qts_pkg::TEXEL_COUNT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,

    input  logic          s_tvalid,
    output logic          s_tready,
    // texel_index, red_in, green_in, blue_in, rect_left, rect_right, rect_top,
    // rect_bottom, row_offset, col_offset
    input  logic [111:0]  s_tdata,
    // command
    input  logic [0:0]    s_tuser,

    output logic          m_tvalid,
    input  logic          m_tready,
    // red_out, green_out, blue_out, screen_x, screen_y, zero pad
    output logic [55:0]   m_tdata,
    // error_code
    output logic [1:0]    m_tuser
);

    localparam int CW      = qts_pkg::CFG_W;
    localparam int DN      = qts_pkg::DIV_N;
    localparam int DD      = qts_pkg::DIV_D;
    localparam int AW      = $clog2(TEXEL_COUNT);
    localparam int IW      = $clog2(TEXEL_COUNT + 1);
    localparam int QW      = IW + 1;
    localparam int PW      = IW + CW;
    localparam int XW      = IW + CW + 1;

    typedef struct packed {
        logic          cmd;
        logic          bad;
        logic          left_nz;
        logic          top_nz;
        logic [12:0]   sx;
        logic [12:0]   sy;
        logic          ld_ok;
        logic [AW-1:0] ld_addr;
        logic [23:0]   rgb;
    } side_t;

    // ---------------- configuration ----------------
    logic [CW-1:0] image_cols_reg;
    logic [CW-1:0] image_rows_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg <= qts_pkg::COLS_RESET;
            image_rows_reg <= qts_pkg::ROWS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                qts_pkg::REG_IMAGE_COLS: image_cols_reg <= pwdata[CW-1:0];
                qts_pkg::REG_IMAGE_ROWS: image_rows_reg <= pwdata[CW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            qts_pkg::REG_IMAGE_COLS: prdata = 32'(image_cols_reg);
            qts_pkg::REG_IMAGE_ROWS: prdata = 32'(image_rows_reg);
        endcase
    end

    // ---------------- flow control ----------------
    logic advance;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // ---------------- stage 1: capture ----------------
    logic        s1_vld_reg;
    logic        s1_cmd_reg;
    logic [15:0] s1_index_reg;
    logic [23:0] s1_rgb_reg;
    logic [11:0] s1_left_reg;
    logic [11:0] s1_right_reg;
    logic [11:0] s1_top_reg;
    logic [11:0] s1_bottom_reg;
    logic [11:0] s1_row_reg;
    logic [11:0] s1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (advance) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg    <= s_tuser[0];
            s1_index_reg  <= s_tdata[15:0];
            s1_rgb_reg    <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
            s1_left_reg   <= s_tdata[51:40];
            s1_right_reg  <= s_tdata[63:52];
            s1_top_reg    <= s_tdata[75:64];
            s1_bottom_reg <= s_tdata[87:76];
            s1_row_reg    <= s_tdata[99:88];
            s1_col_reg    <= s_tdata[111:100];
        end
    end

    // ---------------- stage 2: spans, flags, screen position ----------------
    logic        s2_vld_reg;
    side_t       s2_side_reg;
    logic [11:0] s2_w_reg;
    logic [11:0] s2_h_reg;
    logic [11:0] s2_row_reg;
    logic [11:0] s2_col_reg;
    side_t       s2_side_next;

    always_comb begin
        s2_side_next.cmd     = s1_cmd_reg;
        s2_side_next.bad     = (s1_right_reg <= s1_left_reg) || (s1_bottom_reg <= s1_top_reg);
        s2_side_next.left_nz = (s1_left_reg != '0);
        s2_side_next.top_nz  = (s1_top_reg != '0);
        s2_side_next.sx      = 13'(s1_left_reg) + 13'(s1_col_reg);
        s2_side_next.sy      = 13'(s1_top_reg) + 13'(s1_row_reg);
        s2_side_next.ld_ok   = (32'(s1_index_reg) < 32'(TEXEL_COUNT));
        s2_side_next.ld_addr = AW'(s1_index_reg);
        s2_side_next.rgb     = s1_rgb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (advance) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_side_reg <= s2_side_next;
            s2_w_reg    <= s1_right_reg - s1_left_reg;
            s2_h_reg    <= s1_bottom_reg - s1_top_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    // ---------------- stage 3: dividends ----------------
    logic          s3_vld_reg;
    side_t         s3_side_reg;
    logic [DN-1:0] s3_qx_num_reg;
    logic [DN-1:0] s3_qy_num_reg;
    logic [DN-1:0] s3_px_num_reg;
    logic [DN-1:0] s3_py_num_reg;
    logic [DD-1:0] s3_w_reg;
    logic [DD-1:0] s3_h_reg;
    logic [DD-1:0] s3_w2_reg;
    logic [DD-1:0] s3_h2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (advance) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_side_reg   <= s2_side_reg;
            s3_qx_num_reg <= DN'(s2_w_reg[11:1]) * DN'(image_cols_reg);
            s3_qy_num_reg <= DN'(s2_h_reg[11:1]) * DN'(image_rows_reg);
            s3_px_num_reg <= DN'(s2_col_reg) * DN'(image_cols_reg);
            s3_py_num_reg <= DN'(s2_row_reg) * DN'(image_rows_reg);
            s3_w_reg      <= DD'(s2_w_reg);
            s3_h_reg      <= DD'(s2_h_reg);
            s3_w2_reg     <= {s2_w_reg, 1'b0};
            s3_h2_reg     <= {s2_h_reg, 1'b0};
        end
    end

    // ---------------- divider stages ----------------
    logic [DN-1:0] qx_q;
    logic [DN-1:0] qy_q;
    logic [DN-1:0] px_q;
    logic [DN-1:0] py_q;

    qts_div_pipe #(.N(DN), .D(DD)) u_div_qx (
        .aclk(aclk), .en(advance), .dividend(s3_qx_num_reg), .divisor(s3_w_reg),
        .quotient(qx_q)
    );

    qts_div_pipe #(.N(DN), .D(DD)) u_div_qy (
        .aclk(aclk), .en(advance), .dividend(s3_qy_num_reg), .divisor(s3_h_reg),
        .quotient(qy_q)
    );

    qts_div_pipe #(.N(DN), .D(DD)) u_div_px (
        .aclk(aclk), .en(advance), .dividend(s3_px_num_reg), .divisor(s3_w2_reg),
        .quotient(px_q)
    );

    qts_div_pipe #(.N(DN), .D(DD)) u_div_py (
        .aclk(aclk), .en(advance), .dividend(s3_py_num_reg), .divisor(s3_h2_reg),
        .quotient(py_q)
    );

    logic  vld_line_reg  [DN];
    side_t side_line_reg [DN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DN; i++) begin
                vld_line_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            vld_line_reg[0] <= s3_vld_reg;
            for (int i = 1; i < DN; i++) begin
                vld_line_reg[i] <= vld_line_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_line_reg[0] <= s3_side_reg;
            for (int i = 1; i < DN; i++) begin
                side_line_reg[i] <= side_line_reg[i-1];
            end
        end
    end

    // ---------------- stage 4: quadrant base and clamp ----------------
    side_t       div_side;
    logic [11:0] qx_sel;
    logic [11:0] qy_sel;
    logic [DN:0] row_sum;
    logic [IW-1:0] rows_c_next;
    logic [IW-1:0] px_c_next;

    // rows and column offsets at or past the store size are pinned there; the
    // bound check downstream gives the same answer with narrower arithmetic
    always_comb begin
        div_side    = side_line_reg[DN-1];
        qx_sel      = div_side.left_nz ? qx_q[11:0] : '0;
        qy_sel      = div_side.top_nz ? qy_q[11:0] : '0;
        row_sum     = (DN+1)'(qy_sel) + (DN+1)'(py_q);
        rows_c_next = (row_sum >= (DN+1)'(TEXEL_COUNT)) ? IW'(TEXEL_COUNT) : IW'(row_sum);
        px_c_next   = (px_q >= DN'(TEXEL_COUNT)) ? IW'(TEXEL_COUNT) : IW'(px_q);
    end

    logic          s4_vld_reg;
    side_t         s4_side_reg;
    logic [IW-1:0] s4_rows_reg;
    logic [QW-1:0] s4_cols_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (advance) begin
            s4_vld_reg <= vld_line_reg[DN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s4_side_reg     <= div_side;
            s4_rows_reg     <= rows_c_next;
            s4_cols_off_reg <= QW'(qx_sel) + QW'(px_c_next);
        end
    end

    // ---------------- stage 5: row scaling ----------------
    logic          s5_vld_reg;
    side_t         s5_side_reg;
    logic [PW-1:0] s5_prod_reg;
    logic [QW-1:0] s5_cols_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (advance) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s5_side_reg     <= s4_side_reg;
            s5_prod_reg     <= PW'(s4_rows_reg) * PW'(image_cols_reg);
            s5_cols_off_reg <= s4_cols_off_reg;
        end
    end

    // ---------------- stage 6: index, bound check, store address ----------------
    logic [XW-1:0]  tex_idx;
    qts_pkg::err_t  err_next;

    always_comb begin
        tex_idx = XW'(s5_prod_reg) + XW'(s5_cols_off_reg);
        if (s5_side_reg.bad) begin
            err_next = qts_pkg::ERR_RECT;
        end else if (tex_idx >= XW'(TEXEL_COUNT)) begin
            err_next = qts_pkg::ERR_RANGE;
        end else begin
            err_next = qts_pkg::ERR_OK;
        end
    end

    logic          s6_vld_reg;
    logic          s6_sample_reg;
    logic          s6_we_reg;
    logic [AW-1:0] s6_addr_reg;
    logic [23:0]   s6_wdata_reg;
    qts_pkg::err_t s6_err_reg;
    logic [12:0]   s6_sx_reg;
    logic [12:0]   s6_sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_vld_reg <= 1'b0;
        end else if (advance) begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s6_sample_reg <= (s5_side_reg.cmd == qts_pkg::CMD_SAMPLE);
            s6_we_reg     <= (s5_side_reg.cmd == qts_pkg::CMD_LOAD) && s5_side_reg.ld_ok;
            s6_addr_reg   <= (s5_side_reg.cmd == qts_pkg::CMD_SAMPLE) ?
                             tex_idx[AW-1:0] : s5_side_reg.ld_addr;
            s6_wdata_reg  <= s5_side_reg.rgb;
            s6_err_reg    <= err_next;
            s6_sx_reg     <= s5_side_reg.sx;
            s6_sy_reg     <= s5_side_reg.sy;
        end
    end

    // ---------------- stage 7: texel store access ----------------
    logic [23:0] texel_mem [TEXEL_COUNT];
    logic [23:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s6_vld_reg && s6_we_reg) begin
                texel_mem[s6_addr_reg] <= s6_wdata_reg;
            end else begin
                rd_data_reg <= texel_mem[s6_addr_reg];
            end
        end
    end

    logic          s7_vld_reg;
    logic          s7_sample_reg;
    qts_pkg::err_t s7_err_reg;
    logic [12:0]   s7_sx_reg;
    logic [12:0]   s7_sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (advance) begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s7_sample_reg <= s6_sample_reg;
            s7_err_reg    <= s6_err_reg;
            s7_sx_reg     <= s6_sx_reg;
            s7_sy_reg     <= s6_sy_reg;
        end
    end

    // ---------------- result beat ----------------
    logic [23:0] color;

    assign color    = (s7_err_reg == qts_pkg::ERR_OK) ? rd_data_reg : '0;
    assign m_tvalid = s7_vld_reg && s7_sample_reg;
    assign m_tdata  = {6'b0, s7_sy_reg, s7_sx_reg, color[7:0], color[15:8], color[23:16]};
    assign m_tuser  = s7_err_reg;

endmodule
